FILE: rtl/ascon_pkg.sv
// shared types, constants and helpers for the ascon aead block core
package ascon_pkg;

    localparam int LANE_W     = 64;
    localparam int NUM_LANES  = 5;
    localparam int NUM_ROUNDS = 12;
    localparam int ROUND_W    = 4;
    localparam int RC_W       = 8;
    localparam int CFG_ADDR_W = 2;

    localparam int S_TDATA_W = 320;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 200;
    localparam int M_TUSER_W = 1;

    localparam logic [LANE_W-1:0] ASCON_IV = 64'h80400c0600000000;

    // first round index for a full and a reduced permutation
    localparam logic [ROUND_W-1:0] ROUND_FIRST_FULL = 4'd0;
    localparam logic [ROUND_W-1:0] ROUND_FIRST_HALF = 4'd6;
    localparam logic [ROUND_W-1:0] ROUND_LAST       = 4'd11;

    localparam logic [RC_W-1:0] ROUND_CONST [NUM_ROUNDS] = '{
        8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
        8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
    };

    typedef logic [LANE_W-1:0] lane_t;
    typedef logic [NUM_LANES-1:0][LANE_W-1:0] lanes_t;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_AD    = 2'd1,
        CMD_TEXT  = 2'd2,
        CMD_FINAL = 2'd3
    } cmd_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_KEY_HIGH = 2'd0,
        CFG_KEY_LOW  = 2'd1,
        CFG_DECRYPT  = 2'd2,
        CFG_UNUSED   = 2'd3
    } cfg_addr_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_PERM   = 2'd1,
        ST_FINISH = 2'd2
    } state_t;

    function automatic lane_t rotr(input lane_t v, input int n);
        rotr = (v >> n) | (v << (LANE_W - n));
    endfunction

endpackage

FILE: rtl/ascon_aead_block_core.sv
// ascon aead block core: command sequencer, state lanes and output register
// sequence: start and finalize run accept, the full permutation, then the finish step;
// associated data runs the reduced permutation, or only its accept once it is dropped;
// text runs it too, or skips to finish if none is due; one round of the shared unit per cycle
// result beat is presented the cycle after the finish cycle, held until taken
// rst_n asynchronously clears lanes, flags, key, mode and the output valid
module ascon_aead_block_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [ascon_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ascon_pkg::LANE_W-1:0]         cfg_data,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // data_block, nonce_high, nonce_low, expected_tag_high, expected_tag_low
    input  logic [ascon_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // cmd
    input  logic [ascon_pkg::S_TUSER_W-1:0]      s_axis_tuser,

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // out_block, tag_high, tag_low, tag_match, zero fill
    output logic [ascon_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // is_tag
    output logic [ascon_pkg::M_TUSER_W-1:0]      m_axis_tuser
);

    localparam int LW = ascon_pkg::LANE_W;

    ascon_pkg::state_t                  state_reg, state_next;
    ascon_pkg::lanes_t                  lanes_reg, lanes_next;
    logic                               ds_reg, ds_next;
    logic                               pending_reg, pending_next;
    logic [ascon_pkg::ROUND_W-1:0]      round_reg, round_next;
    ascon_pkg::cmd_t                    cmd_reg, cmd_next;
    ascon_pkg::lane_t                   data_reg, data_next;
    ascon_pkg::lane_t                   exp_hi_reg, exp_hi_next;
    ascon_pkg::lane_t                   exp_lo_reg, exp_lo_next;
    ascon_pkg::lane_t                   key_high_reg, key_low_reg;
    logic                               dec_reg;
    logic                               m_valid_reg, m_valid_next;
    logic [ascon_pkg::M_TDATA_W-1:0]    m_data_reg, m_data_next;
    logic [ascon_pkg::M_TUSER_W-1:0]    m_user_reg, m_user_next;

    ascon_pkg::cmd_t                    in_cmd;
    ascon_pkg::lane_t                   in_data, in_nonce_hi, in_nonce_lo;
    ascon_pkg::lane_t                   in_exp_hi, in_exp_lo;
    ascon_pkg::lanes_t                  round_out;
    logic                               out_free;
    logic                               accept;
    ascon_pkg::lane_t                   res, tag_hi, tag_lo;
    ascon_pkg::lane_t                   ds_flip;

    assign in_cmd      = ascon_pkg::cmd_t'(s_axis_tuser);
    assign in_data     = s_axis_tdata[LW-1:0];
    assign in_nonce_hi = s_axis_tdata[2*LW-1:LW];
    assign in_nonce_lo = s_axis_tdata[3*LW-1:2*LW];
    assign in_exp_hi   = s_axis_tdata[4*LW-1:3*LW];
    assign in_exp_lo   = s_axis_tdata[5*LW-1:4*LW];

    assign out_free = !m_valid_reg || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign ds_flip  = {{(LW-1){1'b0}}, ~ds_reg};

    assign res    = data_reg ^ lanes_reg[0];
    assign tag_hi = lanes_reg[3] ^ key_high_reg;
    assign tag_lo = lanes_reg[4] ^ key_low_reg;

    ascon_round u_round
    (
        .lanes_in    (lanes_reg),
        .round_const (ascon_pkg::ROUND_CONST[round_reg]),
        .lanes_out   (round_out)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ascon_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    case (in_cmd)
                        ascon_pkg::CMD_START: state_next = ascon_pkg::ST_PERM;
                        ascon_pkg::CMD_AD:
                            state_next = ds_reg ? ascon_pkg::ST_IDLE : ascon_pkg::ST_PERM;
                        ascon_pkg::CMD_TEXT:
                            state_next = pending_reg ? ascon_pkg::ST_PERM
                                                     : ascon_pkg::ST_FINISH;
                        ascon_pkg::CMD_FINAL: state_next = ascon_pkg::ST_PERM;
                        default: state_next = ascon_pkg::ST_IDLE;
                    endcase
                end
            end
            ascon_pkg::ST_PERM:
            begin
                if (round_reg == ascon_pkg::ROUND_LAST)
                    state_next = ascon_pkg::ST_FINISH;
            end
            ascon_pkg::ST_FINISH:
            begin
                if (cmd_reg inside {ascon_pkg::CMD_START, ascon_pkg::CMD_AD} || out_free)
                    state_next = ascon_pkg::ST_IDLE;
            end
            default: state_next = ascon_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ascon_pkg::ST_IDLE);
        lanes_next    = lanes_reg;
        ds_next       = ds_reg;
        pending_next  = pending_reg;
        round_next    = round_reg;
        cmd_next      = cmd_reg;
        data_next     = data_reg;
        exp_hi_next   = exp_hi_reg;
        exp_lo_next   = exp_lo_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;

        case (state_reg)
            ascon_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = in_cmd;
                    data_next   = in_data;
                    exp_hi_next = in_exp_hi;
                    exp_lo_next = in_exp_lo;
                    case (in_cmd)
                        ascon_pkg::CMD_START:
                        begin
                            lanes_next[0] = ascon_pkg::ASCON_IV;
                            lanes_next[1] = key_high_reg;
                            lanes_next[2] = key_low_reg;
                            lanes_next[3] = in_nonce_hi;
                            lanes_next[4] = in_nonce_lo;
                            round_next    = ascon_pkg::ROUND_FIRST_FULL;
                            ds_next       = 1'b0;
                            pending_next  = 1'b0;
                        end
                        ascon_pkg::CMD_AD:
                        begin
                            // associated data is absorbed only before the domain bit is dropped
                            if (!ds_reg)
                                lanes_next[0] = lanes_reg[0] ^ in_data;
                            round_next = ascon_pkg::ROUND_FIRST_HALF;
                        end
                        ascon_pkg::CMD_TEXT:
                        begin
                            lanes_next[4] = lanes_reg[4] ^ ds_flip;
                            ds_next       = 1'b1;
                            round_next    = ascon_pkg::ROUND_FIRST_HALF;
                        end
                        ascon_pkg::CMD_FINAL:
                        begin
                            lanes_next[1] = lanes_reg[1] ^ key_high_reg;
                            lanes_next[2] = lanes_reg[2] ^ key_low_reg;
                            lanes_next[4] = lanes_reg[4] ^ ds_flip;
                            ds_next       = 1'b1;
                            round_next    = ascon_pkg::ROUND_FIRST_FULL;
                        end
                        default: ;
                    endcase
                end
            end
            ascon_pkg::ST_PERM:
            begin
                lanes_next = round_out;
                round_next = round_reg + 1'b1;
            end
            ascon_pkg::ST_FINISH:
            begin
                case (cmd_reg)
                    ascon_pkg::CMD_START:
                    begin
                        lanes_next[3] = tag_hi;
                        lanes_next[4] = tag_lo;
                    end
                    ascon_pkg::CMD_TEXT:
                    begin
                        if (out_free)
                        begin
                            lanes_next[0] = dec_reg ? data_reg : res;
                            pending_next  = 1'b1;
                            m_valid_next  = 1'b1;
                            m_data_next   = {7'd0, 1'b0, {LW{1'b0}}, {LW{1'b0}}, res};
                            m_user_next   = 1'b0;
                        end
                    end
                    ascon_pkg::CMD_FINAL:
                    begin
                        if (out_free)
                        begin
                            lanes_next[3] = tag_hi;
                            lanes_next[4] = tag_lo;
                            pending_next  = 1'b0;
                            m_valid_next  = 1'b1;
                            m_data_next   = {7'd0,
                                             (tag_hi == exp_hi_reg) && (tag_lo == exp_lo_reg),
                                             tag_lo, tag_hi, {LW{1'b0}}};
                            m_user_next   = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ascon_pkg::ST_IDLE;
            lanes_reg    <= '0;
            ds_reg       <= 1'b0;
            pending_reg  <= 1'b0;
            round_reg    <= '0;
            cmd_reg      <= ascon_pkg::CMD_START;
            key_high_reg <= '0;
            key_low_reg  <= '0;
            dec_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            lanes_reg   <= lanes_next;
            ds_reg      <= ds_next;
            pending_reg <= pending_next;
            round_reg   <= round_next;
            cmd_reg     <= cmd_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                case (ascon_pkg::cfg_addr_t'(cfg_addr))
                    ascon_pkg::CFG_KEY_HIGH: key_high_reg <= cfg_data;
                    ascon_pkg::CFG_KEY_LOW:  key_low_reg  <= cfg_data;
                    ascon_pkg::CFG_DECRYPT:  dec_reg      <= cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg   <= data_next;
        exp_hi_reg <= exp_hi_next;
        exp_lo_reg <= exp_lo_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // round counter never runs past the last round constant
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ascon_pkg::ST_PERM |-> round_reg <= ascon_pkg::ROUND_LAST)
        else $error("round index out of range");

    // the permutation is only left after its last round
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ascon_pkg::ST_PERM && state_next != ascon_pkg::ST_PERM
        |-> round_reg == ascon_pkg::ROUND_LAST)
        else $error("permutation cut short");

    // a new result beat only comes out of the finish step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg) == ascon_pkg::ST_FINISH)
        else $error("result beat without finish step");

    // a fresh tag beat leaves no text permutation pending
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) && m_user_reg[0] |-> !pending_reg && ds_reg)
        else $error("tag beat with inconsistent flags");

endmodule

FILE: rtl/ascon_round.sv
// one round of the ascon permutation, shared by every permutation step
module ascon_round
(
    input  ascon_pkg::lanes_t           lanes_in,
    input  logic [ascon_pkg::RC_W-1:0]  round_const,
    output ascon_pkg::lanes_t           lanes_out
);

    ascon_pkg::lane_t x0, x1, x2, x3, x4;
    ascon_pkg::lane_t t0, t1, t2, t3, t4;

    always_comb
    begin
        x0 = lanes_in[0];
        x1 = lanes_in[1];
        x2 = lanes_in[2] ^ {{(ascon_pkg::LANE_W-ascon_pkg::RC_W){1'b0}}, round_const};
        x3 = lanes_in[3];
        x4 = lanes_in[4];

        // substitution layer, bit-sliced
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;

        // linear diffusion layer
        lanes_out[0] = x0 ^ ascon_pkg::rotr(x0, 19) ^ ascon_pkg::rotr(x0, 28);
        lanes_out[1] = x1 ^ ascon_pkg::rotr(x1, 61) ^ ascon_pkg::rotr(x1, 39);
        lanes_out[2] = x2 ^ ascon_pkg::rotr(x2, 1) ^ ascon_pkg::rotr(x2, 6);
        lanes_out[3] = x3 ^ ascon_pkg::rotr(x3, 10) ^ ascon_pkg::rotr(x3, 17);
        lanes_out[4] = x4 ^ ascon_pkg::rotr(x4, 7) ^ ascon_pkg::rotr(x4, 41);
    end

endmodule
